FILE: design/lkcd_pkg.sv
// ----------------------------------------------------------------------------
// lkcd_pkg: shared types and constants for the luma keyed cross dilate unit
// Field widths, register indexes, item mode codes and neighbor slots.
// ----------------------------------------------------------------------------
package lkcd_pkg;

  // Fixed field widths
  localparam int unsigned PIX_W      = 32;
  localparam int unsigned FW_W       = 12;  // frame_width register
  localparam int unsigned FH_W       = 13;  // frame_height register
  localparam int unsigned ROW_W      = 12;  // row counter
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // Register reset values and limits
  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;
  localparam logic [FH_W-1:0] MAX_HEIGHT       = 13'd4096;

  // Item mode codes
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // Neighbor slots, candidates in test order after the center
  localparam int unsigned NBR_N     = 5;
  localparam int unsigned NBR_CUR   = 0;
  localparam int unsigned NBR_DOWN  = 1;
  localparam int unsigned NBR_RIGHT = 2;
  localparam int unsigned NBR_UP    = 3;
  localparam int unsigned NBR_LEFT  = 4;

  // Brightness weights
  localparam int unsigned    LUMA_W = 16;
  localparam logic [15:0]    LUMA_R = 16'd90;
  localparam logic [15:0]    LUMA_G = 16'd115;
  localparam logic [15:0]    LUMA_B = 16'd51;

endpackage

FILE: design/lkcd_if.sv
// ----------------------------------------------------------------------------
// lkcd_if: handshake channels of the luma keyed cross dilate unit
// Pixel input, pixel output and configuration write channels.
// ----------------------------------------------------------------------------
interface lkcd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [lkcd_pkg::PIX_W-1:0]  pixel_in;

  modport source (output valid, output mode, output pixel_in, input ready);
  modport sink   (input valid, input mode, input pixel_in, output ready);
endinterface

interface lkcd_out_if;
  logic                        valid;
  logic                        ready;
  logic [lkcd_pkg::PIX_W-1:0]  pixel_out;
  logic                        frame_end;

  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

interface lkcd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [lkcd_pkg::CFG_IDX_W-1:0]   index;
  logic [lkcd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/luma_keyed_cross_dilate_unit.sv
// ----------------------------------------------------------------------------
// luma_keyed_cross_dilate_unit: 3x3 cross dilation keyed on pixel luma
//
//   channel    dir  payload                   accepted when
//   px_in_if   in   mode, pixel_in            valid && ready
//   px_out_if  out  pixel_out, frame_end      valid && ready
//   cfg_if     in   index, data               valid && ready (ready tied high)
//
// One item per cycle sustained while the output is not stalled; each result
// passes the input register, then the result register driving the output.
// Row stores are read one column ahead through registered-read RAMs, so the
// next item finds its neighbors ready. Reset loads 640x480 and clears the
// counters; the row stores are not cleared. A stalled output fills the
// result register, then the input register, and only then drops ready.
// ----------------------------------------------------------------------------
module luma_keyed_cross_dilate_unit #(
  parameter int MAX_WIDTH  = 2048,
  parameter int PIXEL_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lkcd_in_if.sink     px_in_if,
  lkcd_out_if.source  px_out_if,
  lkcd_cfg_if.sink    cfg_if
);

  logic                                       nbr_valid;
  logic                                       nbr_ready;
  logic [lkcd_pkg::NBR_N-1:0][PIXEL_BITS-1:0] nbr;
  logic                                       nbr_end;

  assign cfg_if.ready = 1'b1;

  lkcd_ctrl #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_if.valid),
    .cfg_index_i (cfg_if.index),
    .cfg_data_i  (cfg_if.data),
    .in_valid_i  (px_in_if.valid),
    .in_mode_i   (px_in_if.mode),
    .in_pixel_i  (px_in_if.pixel_in),
    .in_ready_o  (px_in_if.ready),
    .nbr_ready_i (nbr_ready),
    .nbr_valid_o (nbr_valid),
    .nbr_o       (nbr),
    .nbr_end_o   (nbr_end)
  );

  lkcd_pick #(.PIXEL_BITS(PIXEL_BITS)) u_pick (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .nbr_valid_i (nbr_valid),
    .nbr_ready_o (nbr_ready),
    .nbr_i       (nbr),
    .nbr_end_i   (nbr_end),
    .out_valid_o (px_out_if.valid),
    .out_ready_i (px_out_if.ready),
    .out_pixel_o (px_out_if.pixel_out),
    .out_end_o   (px_out_if.frame_end)
  );

endmodule

FILE: design/lkcd_ram.sv
// ----------------------------------------------------------------------------
// lkcd_ram: generic single write port RAM with registered read
// One write and one read address per cycle, no reset on contents.
// ----------------------------------------------------------------------------
module lkcd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/lkcd_ctrl.sv
// ----------------------------------------------------------------------------
// lkcd_ctrl: raster position tracking and line stores
// Holds the frame registers, column and row counters and the two row
// stores, prefetches the next column and assembles the cross neighbors.
// ----------------------------------------------------------------------------
module lkcd_ctrl #(
  parameter int MAX_WIDTH  = 2048,
  parameter int PIXEL_BITS = 32
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           cfg_valid_i,
  input  logic [lkcd_pkg::CFG_IDX_W-1:0]                 cfg_index_i,
  input  logic [lkcd_pkg::CFG_DATA_W-1:0]                cfg_data_i,
  input  logic                                           in_valid_i,
  input  logic                                           in_mode_i,
  input  logic [lkcd_pkg::PIX_W-1:0]                     in_pixel_i,
  output logic                                           in_ready_o,
  input  logic                                           nbr_ready_i,
  output logic                                           nbr_valid_o,
  output logic [lkcd_pkg::NBR_N-1:0][PIXEL_BITS-1:0]     nbr_o,
  output logic                                           nbr_end_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = (CW + 1 > lkcd_pkg::FW_W) ? CW + 1 : lkcd_pkg::FW_W;
  localparam int HW = lkcd_pkg::FH_W;

  logic [lkcd_pkg::FW_W-1:0]  width_q, width_d;
  logic [HW-1:0]              height_q, height_d;
  logic [CW-1:0]              col_q, col_d;
  logic [lkcd_pkg::ROW_W-1:0] row_q, row_d;
  logic                       drain_q, drain_d;
  logic                       hit_a_q, hit_a_d;
  logic                       hit_b_q, hit_b_d;
  logic [PIXEL_BITS-1:0]      prev_q;
  logic [PIXEL_BITS-1:0]      byp_mid_q;
  logic [PIXEL_BITS-1:0]      byp_up_q;

  logic [WW-1:0]              eff_w;
  logic [HW-1:0]              eff_h;
  logic [WW-1:0]              col_nx;
  logic [HW-1:0]              row_nx;
  logic                       col_end;
  logic                       row_end;
  logic                       acc;
  logic                       is_px;
  logic                       px_act;
  logic                       fl_act;
  logic [PIXEL_BITS-1:0]      px_m;
  logic [CW-1:0]              rd_b_addr;
  logic [PIXEL_BITS-1:0]      mid_a_rd, mid_b_rd, up_rd;
  logic [PIXEL_BITS-1:0]      cur, right_raw, up_raw;
  logic                       up_self;

  assign in_ready_o = nbr_ready_i;
  assign acc        = in_valid_i && nbr_ready_i;
  assign is_px      = (in_mode_i == lkcd_pkg::MODE_PIXEL);
  assign px_act     = acc && is_px && !drain_q;
  assign fl_act     = acc && !is_px && drain_q;
  assign px_m       = in_pixel_i[PIXEL_BITS-1:0];

  // Clamp frame size to the supported range
  always_comb begin
    if (width_q == '0) begin
      eff_w = WW'(1);
    end else if (WW'(width_q) > WW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_q);
    end
    if (height_q == '0) begin
      eff_h = HW'(1);
    end else if (height_q > lkcd_pkg::MAX_HEIGHT) begin
      eff_h = lkcd_pkg::MAX_HEIGHT;
    end else begin
      eff_h = height_q;
    end
  end

  assign col_nx  = WW'(col_q) + WW'(1);
  assign row_nx  = HW'(row_q) + HW'(1);
  assign col_end = (col_nx >= eff_w);
  assign row_end = (row_nx >= eff_h);

  // Advance position, take register writes
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    col_d    = col_q;
    row_d    = row_q;
    drain_d  = drain_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        lkcd_pkg::REG_FRAME_WIDTH:  width_d  = cfg_data_i[lkcd_pkg::FW_W-1:0];
        lkcd_pkg::REG_FRAME_HEIGHT: height_d = cfg_data_i;
        default: ;
      endcase
    end
    if (px_act) begin
      if (col_end) begin
        col_d = '0;
        if (row_end) begin
          drain_d = 1'b1;
        end else begin
          row_d = row_nx[lkcd_pkg::ROW_W-1:0];
        end
      end else begin
        col_d = col_nx[CW-1:0];
      end
    end else if (fl_act) begin
      if (col_end) begin
        col_d   = '0;
        row_d   = '0;
        drain_d = 1'b0;
      end else begin
        col_d = col_nx[CW-1:0];
      end
    end
  end

  // Prefetch the next column; forward a same-cycle write to the same entry
  assign rd_b_addr = col_d + CW'(1);
  assign hit_a_d   = px_act && (col_d == col_q);
  assign hit_b_d   = px_act && (rd_b_addr == col_q);

  lkcd_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_mid_a (
    .clk_i   (clk_i),
    .we_i    (px_act),
    .waddr_i (col_q),
    .wdata_i (px_m),
    .raddr_i (col_d),
    .rdata_o (mid_a_rd)
  );

  lkcd_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_mid_b (
    .clk_i   (clk_i),
    .we_i    (px_act),
    .waddr_i (col_q),
    .wdata_i (px_m),
    .raddr_i (rd_b_addr),
    .rdata_o (mid_b_rd)
  );

  lkcd_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_upper (
    .clk_i   (clk_i),
    .we_i    (px_act),
    .waddr_i (col_q),
    .wdata_i (cur),
    .raddr_i (col_d),
    .rdata_o (up_rd)
  );

  assign cur       = hit_a_q ? byp_mid_q : mid_a_rd;
  assign right_raw = hit_b_q ? byp_mid_q : mid_b_rd;
  assign up_raw    = hit_a_q ? byp_up_q  : up_rd;
  assign up_self   = is_px ? (row_q == lkcd_pkg::ROW_W'(1)) : (row_q == '0);

  // Assemble the cross, off-frame neighbors fall back to the center
  always_comb begin
    nbr_o[lkcd_pkg::NBR_CUR]   = cur;
    nbr_o[lkcd_pkg::NBR_DOWN]  = is_px ? px_m : cur;
    nbr_o[lkcd_pkg::NBR_RIGHT] = col_end ? cur : right_raw;
    nbr_o[lkcd_pkg::NBR_UP]    = up_self ? cur : up_raw;
    nbr_o[lkcd_pkg::NBR_LEFT]  = (col_q == '0) ? cur : prev_q;
  end

  assign nbr_valid_o = (px_act && (row_q != '0)) || fl_act;
  assign nbr_end_o   = fl_act && col_end;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= lkcd_pkg::FRAME_WIDTH_RST;
      height_q <= lkcd_pkg::FRAME_HEIGHT_RST;
      col_q    <= '0;
      row_q    <= '0;
      drain_q  <= 1'b0;
      hit_a_q  <= 1'b0;
      hit_b_q  <= 1'b0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
      drain_q  <= drain_d;
      hit_a_q  <= hit_a_d;
      hit_b_q  <= hit_b_d;
    end
  end

  // Hold the previous center as the next left neighbor, and forwarded data
  always_ff @(posedge clk_i) begin
    if (px_act || fl_act) begin
      prev_q <= cur;
    end
    if (px_act) begin
      byp_mid_q <= px_m;
      byp_up_q  <= cur;
    end
  end

endmodule

FILE: design/lkcd_pick.sv
// ----------------------------------------------------------------------------
// lkcd_pick: brightest-pixel selection between input and result registers
// Registers the cross neighbors, picks the brightest by weighted luma and
// registers the result for the output channel.
// ----------------------------------------------------------------------------
module lkcd_pick #(
  parameter int PIXEL_BITS = 32
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       nbr_valid_i,
  output logic                                       nbr_ready_o,
  input  logic [lkcd_pkg::NBR_N-1:0][PIXEL_BITS-1:0] nbr_i,
  input  logic                                       nbr_end_i,
  output logic                                       out_valid_o,
  input  logic                                       out_ready_i,
  output logic [lkcd_pkg::PIX_W-1:0]                 out_pixel_o,
  output logic                                       out_end_o
);

  localparam int LW = lkcd_pkg::LUMA_W;

  logic                                       s1_valid_q;
  logic [lkcd_pkg::NBR_N-1:0][PIXEL_BITS-1:0] s1_nbr_q;
  logic                                       s1_end_q;
  logic                                       out_valid_q;
  logic [PIXEL_BITS-1:0]                      out_pixel_q;
  logic                                       out_end_q;
  logic                                       out_free;
  logic                                       s1_free;
  logic [lkcd_pkg::NBR_N-1:0][LW-1:0]         lum;
  logic [PIXEL_BITS-1:0]                      best;
  logic [LW-1:0]                              best_l;

  function automatic logic [LW-1:0] luma(input logic [PIXEL_BITS-1:0] p);
    logic [LW-1:0] r, g, b;
    r = LW'(p[23:16]);
    g = LW'(p[15:8]);
    b = LW'(p[7:0]);
    return lkcd_pkg::LUMA_R * r + lkcd_pkg::LUMA_G * g + lkcd_pkg::LUMA_B * b;
  endfunction

  assign out_free    = !out_valid_q || out_ready_i;
  assign s1_free     = !s1_valid_q || out_free;
  assign nbr_ready_o = s1_free;

  // Weigh every neighbor, then keep a candidate only if strictly brighter
  always_comb begin
    for (int i = 0; i < lkcd_pkg::NBR_N; i++) begin
      lum[i] = luma(s1_nbr_q[i]);
    end
    best   = s1_nbr_q[lkcd_pkg::NBR_CUR];
    best_l = lum[lkcd_pkg::NBR_CUR];
    for (int i = lkcd_pkg::NBR_DOWN; i <= lkcd_pkg::NBR_LEFT; i++) begin
      if (lum[i] > best_l) begin
        best   = s1_nbr_q[i];
        best_l = lum[i];
      end
    end
  end

  // Advance valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= nbr_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Load input and result payloads
  always_ff @(posedge clk_i) begin
    if (s1_free && nbr_valid_i) begin
      s1_nbr_q <= nbr_i;
      s1_end_q <= nbr_end_i;
    end
    if (out_free && s1_valid_q) begin
      out_pixel_q <= best;
      out_end_q   <= s1_end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pixel_o = lkcd_pkg::PIX_W'(out_pixel_q);
  assign out_end_o   = out_end_q;

endmodule
